### hdl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and codes for the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

   // request type codes
   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // character codes handled by a put request
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LINE_FEED = 8'h0A;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] CHAR_BLANK     = 8'h20;
   localparam logic [7:0] CHAR_LAST      = 8'h7F;

   localparam logic [7:0] ATTR_RESET = 8'h0F;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_WAIT,
      ST_MOVE,
      ST_BLANK,
      ST_RESPOND
   } state_type;

endpackage

### hdl/text_console_character_engine_core.sv
// ----------------------------------------------------------------------------
// text_console_character_engine_core
// Text console: screen cell memory, cursor, put / read / clear requests.
// ----------------------------------------------------------------------------
// One request is handled at a time; req_stall is low only while the engine is
// idle. A put that does not scroll updates the cursor and any cell in the decode
// state and then responds; a read of a cell on screen first waits for the
// registered read port. A clear sweeps the single write port of the cell memory
// over the whole screen before it responds. A put that moves the cursor past the
// bottom row scrolls: every cell of rows 1..ROWS-1 is copied up one row, one
// cell per cycle, then the bottom row is blanked, before it responds. The next
// request can be accepted in the same cycle as the response goes valid. The
// screen memory has no reset; a read of a cell never written returns undefined
// data.
module text_console_character_engine_core #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_cursor_column,
   output logic [4:0]  rsp_cursor_row,
   output logic [10:0] rsp_cursor_location,
   output logic [15:0] rsp_cell_data,
   // attribute register
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);
   import tcce_pkg::*;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int CW         = $clog2(COLUMNS);
   localparam int RW         = $clog2(ROWS);
   localparam int PW         = $clog2(TAB_STOP);
   localparam int SW         = $clog2(COLUMNS + TAB_STOP);

   state_type       state_ff, state_in;

   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [AW-1:0]   base_ff, base_in;     // row * COLUMNS
   logic [PW-1:0]   phase_ff, phase_in;   // col % TAB_STOP
   logic [7:0]      attr_ff, attr_in;

   logic [1:0]      type_ff;
   logic [7:0]      char_ff;
   logic [10:0]     index_ff;

   logic [AW-1:0]   sweep_ff, sweep_in;
   logic            copy_valid_ff, copy_valid_in;
   logic [15:0]     data_ff, data_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [6:0]      rsp_col_ff;
   logic [4:0]      rsp_row_ff;
   logic [10:0]     rsp_loc_ff;
   logic [15:0]     rsp_data_ff;
   logic            rsp_load;

   logic [15:0]     cells [CELL_COUNT];
   logic [15:0]     rd_data_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [15:0]     mem_wdata;
   logic [AW-1:0]   mem_raddr;

   // put decode
   logic            put_write;
   logic [AW-1:0]   put_addr;
   logic [7:0]      put_char;
   logic            put_advance;
   logic            put_scroll;
   logic [CW-1:0]   put_col;
   logic [PW-1:0]   put_phase;
   logic [SW-1:0]   tab_sum;
   logic            index_ok;
   logic            blank_last;
   logic            rsp_free;

   assign tab_sum    = SW'(col_ff) + SW'(TAB_STOP) - SW'(phase_ff);
   assign index_ok   = 32'(index_ff) < CELL_COUNT;
   assign blank_last = sweep_ff == AW'(CELL_COUNT - 1);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign put_scroll = put_advance && (row_ff == RW'(ROWS - 1));

   always_comb begin
      put_write   = 1'b0;
      put_addr    = base_ff + AW'(col_ff);
      put_char    = char_ff;
      put_advance = 1'b0;
      put_col     = col_ff;
      put_phase   = phase_ff;
      case (char_ff)
         CHAR_BACKSPACE: begin
            if (col_ff != '0) begin
               put_write = 1'b1;
               put_addr  = base_ff + AW'(col_ff) - AW'(1);
               put_char  = CHAR_BLANK;
               put_col   = col_ff - CW'(1);
               put_phase = (phase_ff == '0) ? PW'(TAB_STOP - 1) : phase_ff - PW'(1);
            end
         end
         CHAR_TAB: begin
            put_phase = '0;
            if (tab_sum >= SW'(COLUMNS)) begin
               put_col     = '0;
               put_advance = 1'b1;
            end else begin
               put_col = CW'(tab_sum);
            end
         end
         CHAR_RETURN: begin
            put_col   = '0;
            put_phase = '0;
         end
         CHAR_LINE_FEED: begin
            put_col     = '0;
            put_phase   = '0;
            put_advance = 1'b1;
         end
         default: begin
            if (char_ff inside {[CHAR_BLANK:CHAR_LAST]}) begin
               put_write = 1'b1;
               if (col_ff == CW'(COLUMNS - 1)) begin
                  put_col     = '0;
                  put_phase   = '0;
                  put_advance = 1'b1;
               end else begin
                  put_col   = col_ff + CW'(1);
                  put_phase = (phase_ff == PW'(TAB_STOP - 1)) ? '0 : phase_ff + PW'(1);
               end
            end
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (type_ff)
               REQ_PUT:   state_in = put_scroll ? ST_MOVE : ST_RESPOND;
               REQ_READ:  state_in = index_ok ? ST_READ_WAIT : ST_RESPOND;
               REQ_CLEAR: state_in = ST_BLANK;
               default:   state_in = ST_RESPOND;
            endcase
         end
         ST_READ_WAIT: state_in = ST_RESPOND;
         ST_MOVE: begin
            if (sweep_ff == AW'(MOVE_COUNT)) state_in = ST_BLANK;
         end
         ST_BLANK: begin
            if (blank_last) state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory port control
   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      phase_in      = phase_ff;
      attr_in       = csr_write_enable ? csr_write_data : attr_ff;
      sweep_in      = sweep_ff;
      copy_valid_in = 1'b0;
      data_in       = data_ff;
      mem_we        = 1'b0;
      mem_waddr     = sweep_ff;
      mem_wdata     = {attr_ff, CHAR_BLANK};
      mem_raddr     = AW'(index_ff);
      rsp_load      = 1'b0;
      req_stall     = state_ff != ST_IDLE;
      case (state_ff)
         ST_DECODE: begin
            data_in  = '0;
            sweep_in = '0;
            case (type_ff)
               REQ_PUT: begin
                  mem_we    = put_write;
                  mem_waddr = put_addr;
                  mem_wdata = {attr_ff, put_char};
                  col_in    = put_col;
                  phase_in  = put_phase;
                  if (put_advance && !put_scroll) begin
                     row_in  = row_ff + RW'(1);
                     base_in = base_ff + AW'(COLUMNS);
                  end
               end
               REQ_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  base_in  = '0;
                  phase_in = '0;
               end
               default: ;
            endcase
         end
         ST_READ_WAIT: data_in = rd_data_ff;
         ST_MOVE: begin
            // read one row below, write the previous read one cell behind
            mem_raddr = sweep_ff + AW'(COLUMNS);
            mem_we    = copy_valid_ff;
            mem_waddr = sweep_ff - AW'(1);
            mem_wdata = rd_data_ff;
            if (sweep_ff != AW'(MOVE_COUNT)) begin
               copy_valid_in = 1'b1;
               sweep_in      = sweep_ff + AW'(1);
            end
         end
         ST_BLANK: begin
            mem_we = 1'b1;
            if (!blank_last) sweep_in = sweep_ff + AW'(1);
         end
         ST_RESPOND: rsp_load = rsp_free;
         default: ;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_ff        <= '0;
         row_ff        <= '0;
         base_ff       <= '0;
         phase_ff      <= '0;
         attr_ff       <= ATTR_RESET;
         sweep_ff      <= '0;
         copy_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         base_ff       <= base_in;
         phase_ff      <= phase_in;
         attr_ff       <= attr_in;
         sweep_ff      <= sweep_in;
         copy_valid_ff <= copy_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (state_ff == ST_IDLE && req_valid) begin
         type_ff  <= req_type;
         char_ff  <= req_char_code;
         index_ff <= req_cell_index;
      end
      if (rsp_load) begin
         rsp_col_ff  <= 7'(col_ff);
         rsp_row_ff  <= 5'(row_ff);
         rsp_loc_ff  <= 11'(base_ff + AW'(col_ff));
         rsp_data_ff <= data_ff;
      end
   end

   // screen memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) cells[mem_waddr] <= mem_wdata;
      rd_data_ff <= cells[mem_raddr];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_column   = rsp_col_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cursor_location = rsp_loc_ff;
   assign rsp_cell_data       = rsp_data_ff;

endmodule

### sim/tb_text_console_character_engine_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_character_engine_core
// Checks the console engine against a cycle-free model of the cursor and the
// screen. The model follows every accepted request, predicts the cursor and
// cell data for it, and checks responses in order. Phases run under several
// attribute values; idle bursts fall on both channels except in the last.
// ----------------------------------------------------------------------------
module tb_text_console_character_engine_core;
   import tcce_pkg::*;

   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int TAB_STOP = 8;
   localparam int CELLS    = COLUMNS * ROWS;
   localparam int MAX_INDEX = 2047;
   localparam int QUIET_LIMIT = 20000;
   localparam int PHASES = 7;
   localparam int PHASE_REQUESTS = 220;

   // type code the engine does not use
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [6:0]  column;
      logic [4:0]  row;
      logic [10:0] location;
      logic [15:0] data;
   } cursor_report_type;

   class console_model;
      logic [15:0]       cells [CELLS];
      bit                written [CELLS];
      int                column_pos;
      int                row_pos;
      logic [7:0]        attribute;
      cursor_report_type expected_reports [$];
      int                mismatches;

      function new();
         foreach (written[i]) written[i] = 1'b0;
         column_pos = 0;
         row_pos    = 0;
         attribute  = ATTR_RESET;
         mismatches = 0;
      endfunction

      function void set_attribute(logic [7:0] value);
         attribute = value;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      function void store(int at, logic [7:0] code);
         cells[at]   = {attribute, code};
         written[at] = 1'b1;
      endfunction

      function void put_char(logic [7:0] code);
         case (code)
            CHAR_BACKSPACE: begin
               if (column_pos > 0) begin
                  column_pos--;
                  store(row_pos * COLUMNS + column_pos, CHAR_BLANK);
               end
            end
            CHAR_TAB:       column_pos = column_pos + TAB_STOP - (column_pos % TAB_STOP);
            CHAR_RETURN:    column_pos = 0;
            CHAR_LINE_FEED: begin
               column_pos = 0;
               row_pos++;
            end
            default: begin
               if (code >= CHAR_BLANK && code <= CHAR_LAST) begin
                  store(row_pos * COLUMNS + column_pos, code);
                  column_pos++;
               end
            end
         endcase
         if (column_pos >= COLUMNS) begin
            column_pos = 0;
            row_pos++;
         end
         if (row_pos >= ROWS) begin
            // unwritten cells stay unwritten as they move up
            for (int i = 0; i < CELLS - COLUMNS; i++) begin
               cells[i]   = cells[i + COLUMNS];
               written[i] = written[i + COLUMNS];
            end
            for (int i = CELLS - COLUMNS; i < CELLS; i++) store(i, CHAR_BLANK);
            row_pos = ROWS - 1;
         end
      endfunction

      function void note_request(logic [1:0] kind, logic [7:0] code, logic [10:0] index);
         cursor_report_type report;
         report.data = '0;
         case (kind)
            REQ_PUT:   put_char(code);
            REQ_READ:  if (index < CELLS) report.data = cells[index];
            REQ_CLEAR: begin
               for (int i = 0; i < CELLS; i++) store(i, CHAR_BLANK);
               column_pos = 0;
               row_pos    = 0;
            end
            default: ;
         endcase
         report.column   = 7'(column_pos);
         report.row      = 5'(row_pos);
         report.location = 11'(row_pos * COLUMNS + column_pos);
         expected_reports.push_back(report);
      endfunction

      // a written cell, anywhere or in the cursor row, or now and then one off screen
      function logic [10:0] pick_read_index();
         int idx;
         if ($urandom_range(0, 9) == 0) return 11'($urandom_range(CELLS, MAX_INDEX));
         for (int t = 0; t < 32; t++) begin
            if (t % 2 == 0) idx = $urandom_range(0, CELLS - 1);
            else idx = row_pos * COLUMNS + $urandom_range(0, COLUMNS - 1);
            if (written[idx]) return 11'(idx);
         end
         return 11'($urandom_range(CELLS, MAX_INDEX));
      endfunction

      task report_mismatch(string field, logic [15:0] seen, logic [15:0] wanted);
         $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, field, seen,
                  wanted);
         mismatches++;
      endtask

      task check_response(logic [6:0] column, logic [4:0] row, logic [10:0] location,
                          logic [15:0] data);
         cursor_report_type wanted;
         if (expected_reports.size() == 0) begin
            $display("%0t: response with no request outstanding", $realtime);
            mismatches++;
            return;
         end
         wanted = expected_reports.pop_front();
         if (column !== wanted.column)
            report_mismatch("cursor_column", 16'(column), 16'(wanted.column));
         if (row !== wanted.row)
            report_mismatch("cursor_row", 16'(row), 16'(wanted.row));
         if (location !== wanted.location)
            report_mismatch("cursor_location", 16'(location), 16'(wanted.location));
         if (data !== wanted.data) report_mismatch("cell_data", data, wanted.data);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_PUT;
   logic [7:0]  req_char_code = '0;
   logic [10:0] req_cell_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [6:0]  rsp_cursor_column;
   logic [4:0]  rsp_cursor_row;
   logic [10:0] rsp_cursor_location;
   logic [15:0] rsp_cell_data;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = '0;

   console_model model = new();
   bit           idle_enable = 1'b1;
   int           stall_left = 0;
   int           quiet_cycles = 0;

   text_console_character_engine_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_column   (rsp_cursor_column),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_location (rsp_cursor_location),
      .rsp_cell_data       (rsp_cell_data),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // response side back-pressure in bursts
   always @(posedge clock) begin
      if (reset || !idle_enable) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         model.check_response(rsp_cursor_column, rsp_cursor_row, rsp_cursor_location,
                              rsp_cell_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
            $display("tb_text_console_character_engine_core failed");
            $finish;
         end
      end
   end

   task automatic send_request(logic [1:0] kind, logic [7:0] code, logic [10:0] index);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_char_code  <= code;
      req_cell_index <= index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model.note_request(kind, code, index);
   endtask

   task automatic put(logic [7:0] code);
      send_request(REQ_PUT, code, 11'($urandom_range(0, MAX_INDEX)));
   endtask

   task automatic read_cell(logic [10:0] index);
      send_request(REQ_READ, 8'($urandom_range(0, 255)), index);
   endtask

   task automatic random_request();
      int          pick;
      logic [1:0]  kind;
      logic [7:0]  code;
      logic [10:0] index;
      pick  = $urandom_range(0, 99);
      kind  = REQ_PUT;
      code  = 8'($urandom_range(0, 255));
      index = 11'($urandom_range(0, MAX_INDEX));
      if (pick < 2) kind = REQ_CLEAR;
      else if (pick < 3) kind = REQ_UNUSED;
      else if (pick < 23) begin
         kind  = REQ_READ;
         index = model.pick_read_index();
      end
      else if (pick < 28) code = CHAR_LINE_FEED;
      else if (pick < 31) code = CHAR_BACKSPACE;
      else if (pick < 33) code = CHAR_TAB;
      else if (pick < 34) code = CHAR_RETURN;
      else if (pick >= 37) code = 8'($urandom_range(CHAR_BLANK, CHAR_LAST));
      send_request(kind, code, index);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
   endtask

   task automatic write_attribute(logic [7:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model.set_attribute(value);
   endtask

   initial begin
      logic [7:0] attr;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset attribute
      read_cell(11'(MAX_INDEX));
      send_request(REQ_UNUSED, 8'hFF, 11'(MAX_INDEX));
      put(8'h41);
      read_cell(11'd0);
      put(CHAR_BACKSPACE);
      put(CHAR_BACKSPACE);         // at column 0: no effect
      put(CHAR_BLANK);
      put(CHAR_LAST);
      put(8'h80);                  // high codes are ignored
      put(8'hFF);
      put(8'h00);
      put(CHAR_TAB);
      put(CHAR_RETURN);
      put(CHAR_LINE_FEED);
      send_request(REQ_CLEAR, 8'h00, 11'd0);
      read_cell(11'd0);
      repeat (COLUMNS / TAB_STOP) put(CHAR_TAB);   // wraps to the next row
      read_cell(11'(CELLS - 1));

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: attr = 8'h00;
            1: attr = 8'hFF;
            2: attr = 8'hA5;
            3: attr = 8'h5A;
            default: attr = 8'($urandom_range(0, 255));
         endcase
         write_attribute(attr);
         idle_enable = (p != PHASES - 1);
         repeat (PHASE_REQUESTS) random_request();
      end

      drain();
      repeat (20) @(posedge clock);
      if (model.mismatches == 0 && model.pending() == 0)
         $display("tb_text_console_character_engine_core passed");
      else
         $display("tb_text_console_character_engine_core failed");
      $finish;
   end

endmodule
